### rtl/core/gsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gsg_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SLICE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCATTER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREEZE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd4;

    localparam int SLICE_CFG_W = 15;
    localparam int COEF_W      = 16;
    localparam int SLICE_W     = 16;
    localparam int WP_W        = 15;

    localparam logic [SLICE_CFG_W-1:0] SLICE_RST   = 15'd2756;
    localparam logic [COEF_W-1:0]      SCATTER_RST = 16'd32768;
    localparam logic                   FREEZE_RST  = 1'b1;
    localparam logic [COEF_W-1:0]      ATTACK_RST  = 16'd64068;
    localparam logic [COEF_W-1:0]      RELEASE_RST = 16'd65521;

    localparam logic [SLICE_W-1:0] SLICE_MIN = 16'd64;
    // scatter_level * 100 > 65536 is the same as scatter_level > 655
    localparam logic [COEF_W-1:0]  SCATTER_MIN = 16'd655;

    localparam int               LFSR_W    = 32;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 32'h0000_0001;

    localparam int REM_DVD_W = 32;
    localparam int REM_DVS_W = 16;

    typedef struct packed {
        logic                 start;
        logic [REM_DVD_W-1:0] dividend;
        logic [REM_DVS_W-1:0] divisor;
    } rem_req_t;

    typedef struct packed {
        logic                 done;
        logic [REM_DVS_W-1:0] remainder;
    } rem_rsp_t;

endpackage

`default_nettype wire

### rtl/core/gsg_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module gsg_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/gsg_rem.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring remainder, two dividend bits per cycle.
module gsg_rem (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire gsg_pkg::rem_req_t req,
    output gsg_pkg::rem_rsp_t      rsp
);

    import gsg_pkg::*;

    localparam int BITS_PER_CYC = 2;
    localparam int CNT_W        = $clog2(REM_DVD_W / BITS_PER_CYC);

    logic [REM_DVS_W:0]   rem_reg, rem_next;
    logic [REM_DVD_W-1:0] dvd_reg;
    logic [REM_DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    always_comb begin
        logic [REM_DVS_W:0] r;
        r = rem_reg;
        for (int k = 0; k < BITS_PER_CYC; k++) begin
            r = {r[REM_DVS_W-1:0], dvd_reg[REM_DVD_W-1-k]};
            if (r >= {1'b0, dvs_reg}) begin
                r = r - {1'b0, dvs_reg};
            end
        end
        rem_next = r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '1;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_reg << BITS_PER_CYC;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg[REM_DVS_W-1:0];

endmodule

`default_nettype wire

### rtl/core/glitch_stutter_with_transient_gate_top.sv
// Sequence: multiply, envelope update and detect; a passed transient then goes to the output,
// the stutter path writes and reads the ring, scatter adds a remainder division for the read
// offset, and a pointer wrap past a shortened slice adds one more. Throughput: one transaction
// at a time, paced by the shared remainder unit and the one-port-each ring memory sequence.
// Reset: synchronous, active low; afterwards a clearing pass over all CHANNELS * BUF_DEPTH ring
// addresses zeroes the ring and envelope memories, s_tready low, configuration writes taken.
`timescale 1ns / 1ps
`default_nettype none

module glitch_stutter_with_transient_gate_top #(
    parameter int BUF_DEPTH   = 32768,
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 16,
    localparam int TD_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [gsg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [gsg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [TD_W-1:0]                  s_tdata,  // sample_in
    input  wire logic [0:0]                       s_tuser,  // chan
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [TD_W-1:0]                  m_tdata,  // sample_out
    output logic      [0:0]                       m_tuser   // was_transient
);

    import gsg_pkg::*;

    localparam int AW         = $clog2(BUF_DEPTH);
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ENV_DEPTH  = 1 << CH_W;
    localparam int RAM_DEPTH  = CHANNELS * BUF_DEPTH;
    localparam int RAW        = $clog2(RAM_DEPTH);
    localparam int MAG_W      = SAMPLE_BITS;
    localparam int PROD_W     = SAMPLE_BITS + COEF_W;
    localparam int CMP_W      = SAMPLE_BITS + 4;
    localparam int HALF_DEPTH = BUF_DEPTH / 2;

    typedef enum logic [11:0] {
        ST_CLEAR   = 12'b0000_0000_0001,
        ST_IDLE    = 12'b0000_0000_0010,
        ST_MUL     = 12'b0000_0000_0100,
        ST_ENV_UPD = 12'b0000_0000_1000,
        ST_DETECT  = 12'b0000_0001_0000,
        ST_WRITE   = 12'b0000_0010_0000,
        ST_AMT     = 12'b0000_0100_0000,
        ST_DIV     = 12'b0000_1000_0000,
        ST_READ    = 12'b0001_0000_0000,
        ST_RDATA   = 12'b0010_0000_0000,
        ST_PTR     = 12'b0100_0000_0000,
        ST_DONE    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [SLICE_CFG_W-1:0] slice_length_reg;
    logic [COEF_W-1:0]      scatter_level_reg;
    logic                   freeze_enable_reg;
    logic [COEF_W-1:0]      attack_coef_reg;
    logic [COEF_W-1:0]      release_coef_reg;
    logic [SLICE_W-1:0]     slice_sat_reg, slice_sat_next;

    // per-item working registers
    logic [RAW-1:0]         clr_cnt_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [CH_W-1:0]        ch_reg;
    logic                   frozen_reg;
    logic [MAG_W-1:0]       mag_reg;
    logic                   rise_reg;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [MAG_W-1:0]       env_reg, env_next;
    logic                   trans_reg, trans_next;
    logic [31:0]            amt_prod_reg;
    logic [AW-1:0]          rp_reg, rp_next;
    logic [WP_W-1:0]        ptr_reg;
    logic [LFSR_W-1:0]      lfsr_reg, lfsr_next;
    logic [SAMPLE_BITS-1:0] result_reg;
    logic                   m_tvalid_reg;
    logic [SAMPLE_BITS-1:0] m_sample_reg;
    logic                   m_trans_reg;

    logic                   accept;
    logic                   out_free;
    logic                   scatter_on;
    logic [SAMPLE_BITS-1:0] s_sample;
    logic [MAG_W-1:0]       mag_in;
    logic [CH_W-1:0]        ch_in;

    logic [MAG_W-1:0]       env_rdata;
    logic                   env_we;
    logic [CH_W-1:0]        env_waddr;
    logic [MAG_W-1:0]       env_wdata;

    logic                   ring_we;
    logic [RAW-1:0]         ring_waddr;
    logic [SAMPLE_BITS-1:0] ring_wdata;
    logic                   ring_re;
    logic [RAW-1:0]         ring_raddr;
    logic [SAMPLE_BITS-1:0] ring_rdata;
    logic [RAW-1:0]         ring_base;
    logic [AW-1:0]          wp_idx;

    logic [SLICE_W-1:0]     ptr_inc;
    logic [SLICE_W-1:0]     ptr_wrap;
    logic                   need_div;
    logic                   ptr_load;
    logic [WP_W-1:0]        ptr_next;
    logic [REM_DVS_W-1:0]   amt;
    logic [AW:0]            rp_diff;

    rem_req_t rem_req;
    rem_rsp_t rem_rsp;

    // ---------------------------------------------------------------- config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slice_length_reg  <= SLICE_RST;
            scatter_level_reg <= SCATTER_RST;
            freeze_enable_reg <= FREEZE_RST;
            attack_coef_reg   <= ATTACK_RST;
            release_coef_reg  <= RELEASE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SLICE:   slice_length_reg  <= cfg_data[SLICE_CFG_W-1:0];
                CFG_SCATTER: scatter_level_reg <= cfg_data[COEF_W-1:0];
                CFG_FREEZE:  freeze_enable_reg <= cfg_data[0];
                CFG_ATTACK:  attack_coef_reg   <= cfg_data[COEF_W-1:0];
                CFG_RELEASE: release_coef_reg  <= cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate the slice to 64 .. BUF_DEPTH/2
    always_comb begin
        slice_sat_next = {1'b0, slice_length_reg};
        if (slice_sat_next > SLICE_W'(HALF_DEPTH)) begin
            slice_sat_next = SLICE_W'(HALF_DEPTH);
        end
        if (slice_sat_next < SLICE_MIN) begin
            slice_sat_next = SLICE_MIN;
        end
    end

    always_ff @(posedge aclk) begin
        slice_sat_reg <= slice_sat_next;
    end

    // ---------------------------------------------------------------- datapath
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign s_sample   = s_tdata[SAMPLE_BITS-1:0];
    assign mag_in     = s_sample[SAMPLE_BITS-1] ? (~s_sample + 1'b1) : s_sample;
    assign ch_in      = (CHANNELS > 1) ? CH_W'(s_tuser[0]) : '0;
    assign scatter_on = !frozen_reg && (scatter_level_reg > SCATTER_MIN);

    always_comb begin
        logic                   rise;
        logic [MAG_W-1:0]       diff;
        logic [COEF_W-1:0]      coef;
        logic [MAG_W-1:0]       env_dec;
        logic [CMP_W-1:0]       mag10;
        logic [CMP_W-1:0]       env13;
        rise      = mag_reg > env_rdata;
        diff      = rise ? (mag_reg - env_rdata) : (env_rdata - mag_reg);
        coef      = rise ? attack_coef_reg : release_coef_reg;
        prod_next = PROD_W'(diff) * PROD_W'(coef);
        env_dec   = prod_reg[PROD_W-1:COEF_W];
        env_next  = rise_reg ? (mag_reg - env_dec) : (mag_reg + env_dec);
        mag10     = CMP_W'({mag_reg, 3'b000}) + CMP_W'({mag_reg, 1'b0});
        env13     = CMP_W'({env_reg, 3'b000}) + CMP_W'({env_reg, 2'b00}) + CMP_W'(env_reg);
        trans_next = mag10 > env13;
    end

    assign lfsr_next = {1'b0, lfsr_reg[LFSR_W-1:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : '0);

    assign amt = (amt_prod_reg[31:17] == '0) ? REM_DVS_W'(1) : {1'b0, amt_prod_reg[31:17]};

    // read point sits r samples behind the write point, wrapped at the store depth
    assign wp_idx  = AW'(ptr_reg);
    assign rp_diff = {1'b0, wp_idx} - (AW+1)'(rem_rsp.remainder);
    assign rp_next = rp_diff[AW] ? AW'(rp_diff + (AW+1)'(BUF_DEPTH)) : AW'(rp_diff);

    assign ptr_inc  = SLICE_W'(ptr_reg) + 1'b1;
    assign ptr_wrap = ptr_inc - slice_sat_reg;
    assign need_div = (state_reg == ST_RDATA) && !frozen_reg &&
                      (ptr_inc >= slice_sat_reg) && (ptr_wrap >= slice_sat_reg);
    assign ptr_load = ((state_reg == ST_RDATA) && !frozen_reg && !need_div) ||
                      ((state_reg == ST_PTR) && rem_rsp.done);

    always_comb begin
        if (state_reg == ST_PTR) begin
            ptr_next = WP_W'(rem_rsp.remainder);
        end else if (ptr_inc < slice_sat_reg) begin
            ptr_next = WP_W'(ptr_inc);
        end else begin
            ptr_next = WP_W'(ptr_wrap);
        end
    end

    always_comb begin
        rem_req.start    = 1'b0;
        rem_req.dividend = lfsr_reg;
        rem_req.divisor  = amt;
        if (state_reg == ST_AMT) begin
            rem_req.start = 1'b1;
        end else if (need_div) begin
            rem_req.start    = 1'b1;
            rem_req.dividend = REM_DVD_W'(ptr_inc);
            rem_req.divisor  = slice_sat_reg;
        end
    end

    // ---------------------------------------------------------------- memories
    assign env_we    = (state_reg == ST_CLEAR) || (state_reg == ST_ENV_UPD);
    assign env_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg[CH_W-1:0] : ch_reg;
    assign env_wdata = (state_reg == ST_CLEAR) ? '0 : env_next;

    assign ring_base  = RAW'(ch_reg * BUF_DEPTH);
    assign ring_we    = (state_reg == ST_CLEAR) || ((state_reg == ST_WRITE) && !frozen_reg);
    assign ring_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : (ring_base + RAW'(wp_idx));
    assign ring_wdata = (state_reg == ST_CLEAR) ? '0 : sample_reg;
    assign ring_re    = (state_reg == ST_READ);
    assign ring_raddr = ring_base + RAW'(rp_reg);

    gsg_ram #(
        .DEPTH (ENV_DEPTH),
        .WIDTH (MAG_W)
    ) u_env_ram (
        .aclk  (aclk),
        .we    (env_we),
        .waddr (env_waddr),
        .wdata (env_wdata),
        .re    (accept),
        .raddr (ch_in),
        .rdata (env_rdata)
    );

    gsg_ram #(
        .DEPTH (RAM_DEPTH),
        .WIDTH (SAMPLE_BITS)
    ) u_ring_ram (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .re    (ring_re),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    gsg_rem u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rem_req),
        .rsp     (rem_rsp)
    );

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:   if (clr_cnt_reg == RAW'(RAM_DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:    if (accept) state_next = ST_MUL;
            ST_MUL:     state_next = ST_ENV_UPD;
            ST_ENV_UPD: state_next = ST_DETECT;
            ST_DETECT:  state_next = (trans_next && !frozen_reg) ? ST_DONE : ST_WRITE;
            ST_WRITE:   state_next = scatter_on ? ST_AMT : ST_READ;
            ST_AMT:     state_next = ST_DIV;
            ST_DIV:     if (rem_rsp.done) state_next = ST_READ;
            ST_READ:    state_next = ST_RDATA;
            ST_RDATA:   state_next = need_div ? ST_PTR : ST_DONE;
            ST_PTR:     if (rem_rsp.done) state_next = ST_DONE;
            ST_DONE:    if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            ptr_reg      <= '0;
            lfsr_reg     <= LFSR_SEED;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (ptr_load) begin
                ptr_reg <= ptr_next;
            end
            // step the generator only when a scattered read is taken
            if ((state_reg == ST_WRITE) && scatter_on) begin
                lfsr_reg <= lfsr_next;
            end
            if ((state_reg == ST_DONE) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_sample;
            mag_reg    <= mag_in;
            ch_reg     <= ch_in;
            frozen_reg <= freeze_enable_reg;
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= prod_next;
            rise_reg <= mag_reg > env_rdata;
        end
        if (state_reg == ST_ENV_UPD) begin
            env_reg <= env_next;
        end
        if (state_reg == ST_DETECT) begin
            trans_reg  <= trans_next;
            result_reg <= sample_reg;
        end
        if (state_reg == ST_WRITE) begin
            amt_prod_reg <= 32'(scatter_level_reg) * 32'(slice_sat_reg);
            rp_reg       <= wp_idx;
        end
        if ((state_reg == ST_DIV) && rem_rsp.done) begin
            rp_reg <= rp_next;
        end
        if (state_reg == ST_RDATA) begin
            result_reg <= ring_rdata;
        end
        if ((state_reg == ST_DONE) && out_free) begin
            m_sample_reg <= result_reg;
            m_trans_reg  <= trans_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = TD_W'(m_sample_reg);
    assign m_tuser[0] = m_trans_reg;

    // ---------------------------------------------------------------- checks
    a_ptr_in_slice: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(ptr_load) |-> (SLICE_W'(ptr_reg) < $past(slice_sat_reg)))
        else $error("write pointer left the slice after an update");

    a_lfsr_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        lfsr_reg != '0)
        else $error("random generator locked at zero");

    a_rem_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_rsp.done |-> (state_reg == ST_DIV || state_reg == ST_PTR))
        else $error("remainder finished with no waiting sequencer state");

    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result presented without a finished transaction");

    a_no_frozen_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (ring_we && state_reg != ST_CLEAR) |-> !frozen_reg && $past(state_reg == ST_DETECT))
        else $error("ring written while frozen or out of sequence");

endmodule

`default_nettype wire
